>>> hw/rtl/qvcc_pkg.sv
// ----------------------------------------------------------------------------
// qvcc_pkg
// Shared types, codes and constants for the quadrature volume and channel
// control unit.
// ----------------------------------------------------------------------------
package qvcc_pkg;

   localparam int unsigned ATTENUATION_BITS_DEF = 8;

   // Configuration reset values.
   localparam logic [6:0] ATT_STEP_RESET      = 7'd4;
   localparam logic [3:0] ATT_DETENT_RESET    = 4'd2;
   localparam logic [3:0] CHAN_DETENT_RESET   = 4'd6;
   localparam logic [3:0] HIGHEST_CHAN_RESET  = 4'd3;

   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam int unsigned CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_ATT_STEP     = 2'd0,
      REG_ATT_DETENT   = 2'd1,
      REG_CHAN_DETENT  = 2'd2,
      REG_HIGHEST_CHAN = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_BUTTON = 1'b1
   } op_type;

   typedef enum logic {
      MODE_ATT  = 1'b0,
      MODE_CHAN = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      SENSE_UNDECIDED = 2'd0,
      SENSE_CCW       = 2'd1,
      SENSE_CW        = 2'd2
   } sense_type;

   // Decode of {previous A, previous B, current A, current B}.
   localparam logic signed [1:0] STEP_TABLE [16] = '{
      2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
      -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
   };

   typedef struct packed {
      logic [6:0] att_step;
      logic [3:0] att_detent;
      logic [3:0] chan_detent;
      logic [3:0] highest_chan;
   } cfg_type;

   typedef struct packed {
      op_type operation;
      logic   phase_a;
      logic   phase_b;
   } item_type;

   // Last field listed sits in the lowest bits.
   typedef struct packed {
      sense_type  rotation_sense;
      mode_type   adjust_mode;
      logic [3:0] selected_channel;
      logic [7:0] attenuation;
   } result_type;

endpackage

>>> hw/rtl/quadrature_volume_channel_control_unit.sv
// ----------------------------------------------------------------------------
// quadrature_volume_channel_control_unit
// Rotary encoder front end that adjusts an attenuation level or an input
// channel, with a push button to switch between the two.
// ----------------------------------------------------------------------------
// Each word on the req_ channel is either an encoder sample (req_tuser low,
// phase levels in req_tdata) or a button press (req_tuser high). Every word
// produces exactly one word on the rsp_ channel holding the attenuation,
// channel, adjust mode and rotation sense as they stand after that word.
//
// The whole update is one pass of combinational logic from the encoder
// state registers, so a word is accepted whenever req_tready is high and
// its result is registered in the output buffer that drives rsp_tvalid.
// The state update loop gives one word per cycle unless rsp_ stalls.
//
// The result side is a two-entry buffer. When the receiver stalls, one more
// input word is still taken into the skid entry; req_tready then drops
// until the receiver drains a word. No word is lost or repeated.
//
// Reset sets the attenuation to its maximum, selects channel zero and
// attenuation mode, clears both phase histories and counts, leaves the
// rotation sense undecided and loads the register defaults. The csr_ port
// should only be written while the block is idle.
module quadrature_volume_channel_control_unit #(
   parameter int unsigned ATTENUATION_BITS = qvcc_pkg::ATTENUATION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] phase_a, [1] phase_b, [7:2] zero
   input  logic        req_tuser,   // [0] operation

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] attenuation, [11:8] selected_channel, [12] adjust_mode,
   // [14:13] rotation_sense, [15] zero
   output logic [15:0] rsp_tdata,

   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [qvcc_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [qvcc_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [qvcc_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   qvcc_pkg::cfg_type       cfg_ff, cfg_in;
   qvcc_pkg::reg_index_type csr_index;
   logic                    csr_write;
   qvcc_pkg::item_type      item;
   qvcc_pkg::result_type    push_word, out_word;
   logic                    req_accept;

   // ------------------------------------------------------------------------
   // Register port. Writes land on the access cycle; reads are a plain mux.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = qvcc_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            qvcc_pkg::REG_ATT_STEP:     cfg_in.att_step     = csr_pwdata[6:0];
            qvcc_pkg::REG_ATT_DETENT:   cfg_in.att_detent   = csr_pwdata[3:0];
            qvcc_pkg::REG_CHAN_DETENT:  cfg_in.chan_detent  = csr_pwdata[3:0];
            qvcc_pkg::REG_HIGHEST_CHAN: cfg_in.highest_chan = csr_pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         qvcc_pkg::REG_ATT_STEP:     csr_prdata = 32'(cfg_ff.att_step);
         qvcc_pkg::REG_ATT_DETENT:   csr_prdata = 32'(cfg_ff.att_detent);
         qvcc_pkg::REG_CHAN_DETENT:  csr_prdata = 32'(cfg_ff.chan_detent);
         qvcc_pkg::REG_HIGHEST_CHAN: csr_prdata = 32'(cfg_ff.highest_chan);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.att_step     <= qvcc_pkg::ATT_STEP_RESET;
         cfg_ff.att_detent   <= qvcc_pkg::ATT_DETENT_RESET;
         cfg_ff.chan_detent  <= qvcc_pkg::CHAN_DETENT_RESET;
         cfg_ff.highest_chan <= qvcc_pkg::HIGHEST_CHAN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ------------------------------------------------------------------------
   // Input side. The ready only depends on the skid entry being free.
   // ------------------------------------------------------------------------
   assign req_accept     = req_tvalid && req_tready;
   assign item.operation = qvcc_pkg::op_type'(req_tuser);
   assign item.phase_a   = req_tdata[0];
   assign item.phase_b   = req_tdata[1];

   qvcc_core #(
      .ATTENUATION_BITS (ATTENUATION_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .item   (item),
      .cfg    (cfg_ff),
      .result (push_word)
   );

   qvcc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_word (push_word),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_word  (out_word),
      .room      (req_tready)
   );

   assign rsp_tdata = {1'b0, out_word};

   // ------------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------------

   // A full buffer always has a word on offer at the output.
   a_full_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input blocked with no result word pending");

   // A word taken while the output is stalled must fill the skid entry.
   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_tvalid && !rsp_tready) |=> !req_tready)
      else $error("second word accepted under stall did not close the input");

   // A channel-mode sample never leaves the channel above the highest one.
   a_channel_bound: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !csr_write && item.operation == qvcc_pkg::OP_SAMPLE &&
       push_word.adjust_mode == qvcc_pkg::MODE_CHAN)
      |-> (push_word.selected_channel <= cfg_ff.highest_chan))
      else $error("channel outside the configured range");

   // A button press always reports an undecided sense.
   a_button_clears_sense: assert property (@(posedge clock) disable iff (reset)
      (req_accept && item.operation == qvcc_pkg::OP_BUTTON)
      |-> (push_word.rotation_sense == qvcc_pkg::SENSE_UNDECIDED))
      else $error("button press did not clear the rotation sense");

endmodule

>>> hw/rtl/qvcc_core.sv
// ----------------------------------------------------------------------------
// qvcc_core
// Encoder state and combinational update: table decode, direction tracking,
// detent counting and the attenuation and channel steps.
// ----------------------------------------------------------------------------
module qvcc_core #(
   parameter int unsigned ATTENUATION_BITS = qvcc_pkg::ATTENUATION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  qvcc_pkg::item_type   item,
   input  qvcc_pkg::cfg_type    cfg,
   output qvcc_pkg::result_type result
);

   localparam int unsigned AW = ATTENUATION_BITS;
   localparam int unsigned VW = ((AW > 7) ? AW : 7) + 2;
   localparam int unsigned LW = (AW > 8) ? AW : 8;
   localparam logic [AW-1:0] ATT_MAX = '1;

   logic [1:0]          hist_ff  [2];
   logic [1:0]          hist_in  [2];
   logic signed [4:0]   count_ff [2];
   logic signed [4:0]   count_in [2];
   qvcc_pkg::sense_type sense_ff, sense_in, sense_nx;
   qvcc_pkg::mode_type  mode_ff, mode_in;
   logic [AW-1:0]       level_ff, level_in, level_nx;
   logic [3:0]          chan_ff, chan_in, chan_nx;

   logic                m;
   logic [3:0]          idx;
   logic signed [1:0]   delta;
   logic                reverse;
   logic signed [5:0]   sum;
   logic [3:0]          thr;
   logic signed [5:0]   thr_pos, thr_neg;
   logic                hit_up, hit_dn;
   logic signed [VW-1:0] lvl_s, stp_s, max_s, att_v;
   logic signed [5:0]   chan_v, high_s;
   logic [LW-1:0]       level_wide;

   assign m     = mode_ff;
   assign idx   = {hist_ff[m], item.phase_a, item.phase_b};
   assign delta = qvcc_pkg::STEP_TABLE[idx];

   always_comb begin
      sense_nx = sense_ff;
      reverse  = 1'b0;
      case (sense_ff)
         qvcc_pkg::SENSE_UNDECIDED: begin
            if (delta < 0) begin
               sense_nx = qvcc_pkg::SENSE_CCW;
            end else if (delta > 0) begin
               sense_nx = qvcc_pkg::SENSE_CW;
            end
         end
         qvcc_pkg::SENSE_CCW: begin
            if (delta > 0) begin
               sense_nx = qvcc_pkg::SENSE_CW;
               reverse  = 1'b1;
            end
         end
         qvcc_pkg::SENSE_CW: begin
            if (delta < 0) begin
               sense_nx = qvcc_pkg::SENSE_CCW;
               reverse  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // A reversal drops whatever was counted in the old direction.
   assign sum = (reverse ? 6'sd0 : {count_ff[m][4], count_ff[m]})
                + {{4{delta[1]}}, delta};
   assign thr     = (m == 1'b0) ? cfg.att_detent : cfg.chan_detent;
   assign thr_pos = $signed({2'b00, thr});
   assign thr_neg = -thr_pos;
   assign hit_up  = (sum >= thr_pos);
   assign hit_dn  = !hit_up && (sum <= thr_neg);

   // Attenuation moves against the rotation and saturates.
   assign lvl_s = $signed(VW'(level_ff));
   assign stp_s = $signed(VW'(cfg.att_step));
   assign max_s = $signed(VW'(ATT_MAX));
   assign att_v = hit_up ? (lvl_s - stp_s) : (hit_dn ? (lvl_s + stp_s) : lvl_s);

   always_comb begin
      if (att_v[VW-1]) begin
         level_nx = '0;
      end else if (att_v > max_s) begin
         level_nx = ATT_MAX;
      end else begin
         level_nx = att_v[AW-1:0];
      end
   end

   // The channel follows the rotation and wraps at both ends.
   assign high_s = $signed({2'b00, cfg.highest_chan});
   assign chan_v = $signed({2'b00, chan_ff})
                   + (hit_up ? 6'sd1 : (hit_dn ? -6'sd1 : 6'sd0));

   always_comb begin
      if (chan_v > high_s) begin
         chan_nx = 4'd0;
      end else if (chan_v[5]) begin
         chan_nx = cfg.highest_chan;
      end else begin
         chan_nx = chan_v[3:0];
      end
   end

   always_comb begin
      hist_in  = hist_ff;
      count_in = count_ff;
      sense_in = sense_ff;
      mode_in  = mode_ff;
      level_in = level_ff;
      chan_in  = chan_ff;
      if (accept) begin
         if (item.operation == qvcc_pkg::OP_BUTTON) begin
            mode_in       = (mode_ff == qvcc_pkg::MODE_ATT) ? qvcc_pkg::MODE_CHAN
                                                            : qvcc_pkg::MODE_ATT;
            sense_in      = qvcc_pkg::SENSE_UNDECIDED;
            hist_in[~m]   = 2'b00;
            count_in[~m]  = 5'sd0;
         end else begin
            hist_in[m]  = {item.phase_a, item.phase_b};
            sense_in    = sense_nx;
            count_in[m] = (hit_up || hit_dn) ? 5'sd0 : sum[4:0];
            if (m == 1'b0) begin
               level_in = level_nx;
            end else begin
               chan_in = chan_nx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '{default: 2'b00};
         count_ff <= '{default: 5'sd0};
         sense_ff <= qvcc_pkg::SENSE_UNDECIDED;
         mode_ff  <= qvcc_pkg::MODE_ATT;
         level_ff <= ATT_MAX;
         chan_ff  <= 4'd0;
      end else begin
         hist_ff  <= hist_in;
         count_ff <= count_in;
         sense_ff <= sense_in;
         mode_ff  <= mode_in;
         level_ff <= level_in;
         chan_ff  <= chan_in;
      end
   end

   assign level_wide              = LW'(level_in);
   assign result.attenuation      = level_wide[7:0];
   assign result.selected_channel = chan_in;
   assign result.adjust_mode      = mode_in;
   assign result.rotation_sense   = sense_in;

endmodule

>>> hw/rtl/qvcc_out_buf.sv
// ----------------------------------------------------------------------------
// qvcc_out_buf
// Two-entry result buffer: an output register backed by a skid register so
// the input side keeps a registered ready.
// ----------------------------------------------------------------------------
module qvcc_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qvcc_pkg::result_type push_word,
   input  logic                 out_ready,
   output logic                 out_valid,
   output qvcc_pkg::result_type out_word,
   output logic                 room
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   qvcc_pkg::result_type out_word_ff, out_word_in;
   qvcc_pkg::result_type skid_word_ff, skid_word_in;
   logic                 pop;

   assign pop = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_word_in  = push_word;
            out_valid_in = 1'b1;
         end else begin
            skid_word_in  = push_word;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;
   assign room      = !skid_valid_ff;

endmodule
